// ----- src/gtb_pkg.sv -----
// gtb_pkg: shared types, opcodes and constants for the guest timebase block
// no dependencies
`default_nettype none
package gtb_pkg;
    // opcodes of the input word
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_REBASE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FREQ   = 2'd0;
    localparam logic [1:0] CFG_SHIFT  = 2'd1;
    localparam logic [1:0] CFG_LEGACY = 2'd2;

    localparam logic [31:0] FREQ_RESET  = 32'd24000000;
    localparam logic [2:0]  SHIFT_RESET = 3'd3;

    localparam logic [63:0] GUEST_CORE_CLOCK = 64'd1243125000;
    localparam int          FRAC_BITS        = 55;
    localparam int          INT_SHIFT        = 64 - FRAC_BITS;
    localparam int          GUEST_SCALE_SH   = 3;
    // core clock times eight, as a 73.55 fixed-point numerator
    localparam logic [127:0] PUB_DIVIDEND =
        128'(GUEST_CORE_CLOCK * 64'd8) << FRAC_BITS;

    // shared unit commands and status
    typedef struct packed {
        logic mul;
        logic div;
    } gtb_arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gtb_arith_sts_t;
endpackage
`default_nettype wire

// ----- src/gtb_if.sv -----
// gtb_in_if / gtb_out_if: valid-ready channels of the guest timebase block
// no dependencies
`default_nettype none
interface gtb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] counter_value;
    modport source (output valid, output opcode, output counter_value, input ready);
    modport sink (input valid, input opcode, input counter_value, output ready);
endinterface

interface gtb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] timebase;
    logic        multiplier_truncated;
    modport source (output valid, output timebase, output multiplier_truncated, input ready);
    modport sink (input valid, input timebase, input multiplier_truncated, output ready);
endinterface
`default_nettype wire

// ----- src/guest_timebase_from_counter_unit.sv -----
// guest_timebase_from_counter_unit: host counter to guest timebase, top level
// depends on gtb_pkg, gtb_if, gtb_arith
//
// usage:
//   in_ch carries one word per request: opcode (read, start, rebase) and the
//   host counter value. out_ch returns one word per request: the guest
//   timebase and the multiplier truncation flag. configuration is written
//   through cfg_wr_en / cfg_index / cfg_data while no request is in flight.
// sequencing:
//   one request at a time; in_ch.ready is high only while the sequencer idles.
//   an anchored read with an anchor runs four 32x32 partial products in the
//   shared unit; a legacy read multiplies, then runs the 128/32 divider at two
//   quotient bits per cycle; a rebase divides, multiplying first if an anchor
//   is valid. unused opcodes and a zero frequency skip the divider.
// reset:
//   rst_n clears all timebase state, the anchor and the output valid flag; the
//   configuration returns to 24 MHz, shift 3, anchored mode.
// stalls:
//   a finished word sits in the output register until out_ch.ready; the next
//   request may be accepted meanwhile, and its result waits until the output
//   register frees up.
`default_nettype none
module guest_timebase_from_counter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gtb_in_if.sink           in_ch,
    gtb_out_if.source        out_ch,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_PUBZ = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [31:0]  freq_reg;
    logic [2:0]   ts_reg;
    logic         leg_reg;
    logic [63:0]  last_reg;
    logic [31:0]  racc_reg;
    logic [63:0]  total_reg;
    logic         av_reg;
    logic [63:0]  ac_reg;
    logic [63:0]  at_reg;
    logic [63:0]  am_reg;
    logic [2:0]   ash_reg;
    logic [2:0]   state_reg;
    logic [2:0]   state_next;
    logic [1:0]   op_reg;
    logic [63:0]  now_reg;
    logic [63:0]  carry_reg;
    logic [63:0]  res_tb_reg;
    logic         res_tr_reg;
    logic         ov_reg;
    logic [63:0]  otb_reg;
    logic         otr_reg;

    gtb_pkg::gtb_arith_cmd_t cmd;
    gtb_pkg::gtb_arith_sts_t sts;
    logic [63:0]  op_a;
    logic [63:0]  op_b;
    logic [127:0] load;
    logic [127:0] ar_work;
    logic [31:0]  ar_rem;

    logic         acc;
    logic         leg_read;
    logic [63:0]  delta;
    logic [63:0]  delta_c;
    logic [63:0]  anch_val;
    logic [63:0]  lq;
    logic [63:0]  new_total;
    logic         out_free;

    gtb_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .op_a    (op_a),
        .op_b    (op_b),
        .load    (load),
        .divisor (freq_reg),
        .sts     (sts),
        .work    (ar_work),
        .rem     (ar_rem)
    );

    assign acc      = in_ch.valid && in_ch.ready;
    assign leg_read = (op_reg == gtb_pkg::OP_READ) && leg_reg;
    assign delta    = in_ch.counter_value - last_reg;
    assign delta_c  = delta[63] ? 64'd0 : delta;
    assign out_free = !ov_reg || out_ch.ready;

    // anchored value from the multiplier's high half
    assign anch_val = at_reg + ((ar_work[127:64] << gtb_pkg::INT_SHIFT) >> ash_reg);

    // legacy quotient with saturation, scaled and added to the total
    assign lq = (state_reg == ST_DIV && ar_work[127:64] == 64'd0) ? ar_work[63:0] : '1;
    assign new_total = total_reg + ((lq << gtb_pkg::GUEST_SCALE_SH) >> ts_reg);

    // sequencer
    always_comb
    begin
        cmd        = '0;
        op_a       = in_ch.counter_value - ac_reg;
        op_b       = am_reg;
        load       = gtb_pkg::PUB_DIVIDEND;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (in_ch.opcode)
                        gtb_pkg::OP_READ, gtb_pkg::OP_REBASE:
                        begin
                            if (in_ch.opcode == gtb_pkg::OP_READ && leg_reg)
                            begin
                                cmd.mul    = 1'b1;
                                op_a       = delta_c;
                                op_b       = gtb_pkg::GUEST_CORE_CLOCK;
                                load       = {96'd0, racc_reg};
                                state_next = ST_MUL;
                            end
                            else if (av_reg)
                            begin
                                cmd.mul    = 1'b1;
                                load       = '0;
                                state_next = ST_MUL;
                            end
                            else if (freq_reg != 32'd0)
                            begin
                                cmd.div    = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                                state_next = ST_PUBZ;
                        end
                        gtb_pkg::OP_START:
                        begin
                            if (freq_reg != 32'd0)
                            begin
                                cmd.div    = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                                state_next = ST_PUBZ;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL:
            begin
                if (sts.done)
                begin
                    if (leg_read)
                    begin
                        if (freq_reg != 32'd0)
                        begin
                            cmd.div    = 1'b1;
                            load       = ar_work;
                            state_next = ST_DIV;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    else if (op_reg == gtb_pkg::OP_READ)
                        state_next = ST_DONE;
                    else if (freq_reg != 32'd0)
                    begin
                        cmd.div    = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_PUBZ;
                end
            end
            ST_DIV:
            begin
                if (sts.done)
                    state_next = ST_DONE;
            end
            ST_PUBZ: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and timebase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            freq_reg  <= gtb_pkg::FREQ_RESET;
            ts_reg    <= gtb_pkg::SHIFT_RESET;
            leg_reg   <= 1'b0;
            last_reg  <= '0;
            racc_reg  <= '0;
            total_reg <= '0;
            av_reg    <= 1'b0;
            ac_reg    <= '0;
            at_reg    <= '0;
            am_reg    <= '0;
            ash_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    gtb_pkg::CFG_FREQ:   freq_reg <= cfg_data;
                    gtb_pkg::CFG_SHIFT:  ts_reg   <= cfg_data[2:0];
                    gtb_pkg::CFG_LEGACY: leg_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            // request accepted
            if (state_reg == ST_IDLE && acc)
            begin
                if (in_ch.opcode == gtb_pkg::OP_READ && leg_reg &&
                    in_ch.counter_value > last_reg)
                    last_reg <= in_ch.counter_value;
                if (in_ch.opcode == gtb_pkg::OP_START)
                begin
                    last_reg  <= in_ch.counter_value;
                    total_reg <= '0;
                end
            end

            // legacy read with zero frequency
            if (state_reg == ST_MUL && sts.done && leg_read && freq_reg == 32'd0)
            begin
                racc_reg  <= '0;
                total_reg <= new_total;
            end

            // legacy divide finished
            if (state_reg == ST_DIV && sts.done && leg_read)
            begin
                racc_reg  <= ar_rem;
                total_reg <= new_total;
            end

            // publish an anchor
            if ((state_reg == ST_DIV && sts.done && !leg_read) || state_reg == ST_PUBZ)
            begin
                av_reg  <= 1'b1;
                ac_reg  <= now_reg;
                at_reg  <= carry_reg;
                am_reg  <= (state_reg == ST_PUBZ) ? '1 : ar_work[63:0];
                ash_reg <= ts_reg;
            end

            // output register
            if (state_reg == ST_DONE && out_free)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && acc)
        begin
            op_reg     <= in_ch.opcode;
            now_reg    <= in_ch.counter_value;
            carry_reg  <= '0;
            res_tb_reg <= '0;
            res_tr_reg <= 1'b0;
        end
        if (state_reg == ST_MUL && sts.done)
        begin
            if (leg_read)
            begin
                res_tb_reg <= new_total;
                res_tr_reg <= 1'b0;
            end
            else if (op_reg == gtb_pkg::OP_READ)
            begin
                res_tb_reg <= anch_val;
                res_tr_reg <= 1'b0;
            end
            else
                carry_reg <= anch_val;
        end
        if (state_reg == ST_DIV && sts.done)
        begin
            if (leg_read)
            begin
                res_tb_reg <= new_total;
                res_tr_reg <= 1'b0;
            end
            else
            begin
                res_tb_reg <= carry_reg;
                res_tr_reg <= (ar_work[127:64] != 64'd0);
            end
        end
        if (state_reg == ST_PUBZ)
        begin
            res_tb_reg <= carry_reg;
            res_tr_reg <= 1'b1;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            otb_reg <= res_tb_reg;
            otr_reg <= res_tr_reg;
        end
    end

    assign in_ch.ready                 = (state_reg == ST_IDLE);
    assign out_ch.valid                = ov_reg;
    assign out_ch.timebase             = otb_reg;
    assign out_ch.multiplier_truncated = otr_reg;

`ifndef SYNTHESIS
    // shared unit is never busy while a new word can come in
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !sts.busy)
        else $error("shared unit busy while accepting");

    // an accepted word always takes the sequencer out of idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !in_ch.ready)
        else $error("sequencer stayed idle after accept");

    // once published, an anchor stays valid until reset
    a_anchor_keep: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(av_reg))
        else $error("anchor valid dropped");
`endif
endmodule
`default_nettype wire

// ----- src/gtb_arith.sv -----
// gtb_arith: shared 64x64 multiplier (four 32x32 partials) and 128/32 divider
// depends on gtb_pkg
`default_nettype none
module gtb_arith (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire gtb_pkg::gtb_arith_cmd_t cmd,
    input  wire logic [63:0]             op_a,
    input  wire logic [63:0]             op_b,
    input  wire logic [127:0]            load,
    input  wire logic [31:0]             divisor,
    output gtb_pkg::gtb_arith_sts_t      sts,
    output logic [127:0]                 work,
    output logic [31:0]                  rem
);
    logic         busy_reg;
    logic         done_reg;
    logic         div_mode_reg;
    logic [5:0]   cnt_reg;
    logic         pv_reg;
    logic [1:0]   sh_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [31:0]  d_reg;
    logic [63:0]  prod_reg;
    logic [127:0] work_reg;
    logic [31:0]  rem_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] addend;
    logic [32:0]  t1;
    logic [32:0]  t2;
    logic         ge1;
    logic         ge2;
    logic [31:0]  r1;
    logic [31:0]  r2;

    // partial product operand select
    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    // aligned partial product
    always_comb
    begin
        case (sh_reg)
            2'd0:    addend = {64'd0, prod_reg};
            2'd1:    addend = {32'd0, prod_reg, 32'd0};
            2'd2:    addend = {prod_reg, 64'd0};
            default: addend = '0;
        endcase
    end

    // two restoring division steps per cycle
    always_comb
    begin
        t1  = {rem_reg, work_reg[127]};
        ge1 = t1 >= {1'b0, d_reg};
        r1  = ge1 ? 32'(t1 - {1'b0, d_reg}) : t1[31:0];
        t2  = {r1, work_reg[126]};
        ge2 = t2 >= {1'b0, d_reg};
        r2  = ge2 ? 32'(t2 - {1'b0, d_reg}) : t2[31:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            div_mode_reg <= 1'b0;
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && (cmd.mul || cmd.div))
            begin
                busy_reg     <= 1'b1;
                div_mode_reg <= cmd.div;
                cnt_reg      <= '0;
                pv_reg       <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (div_mode_reg)
                begin
                    if (cnt_reg == 6'd63)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    pv_reg <= (cnt_reg < 6'd4);
                    if (cnt_reg == 6'd4)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (!busy_reg && (cmd.mul || cmd.div))
        begin
            a_reg    <= op_a;
            b_reg    <= op_b;
            d_reg    <= divisor;
            work_reg <= load;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (div_mode_reg)
            begin
                rem_reg  <= r2;
                work_reg <= {work_reg[125:0], ge1, ge2};
            end
            else
            begin
                prod_reg <= 64'(a_half) * 64'(b_half);
                sh_reg   <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                if (pv_reg)
                    work_reg <= work_reg + addend;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign work     = work_reg;
    assign rem      = rem_reg;
endmodule
`default_nettype wire
